>>> design/pbs_pkg.sv
`timescale 1ns / 1ps
// Package of the pixel background subtractor: widths, register codes, item types
// and the per-channel arithmetic shared by the pipeline modules.
// Depends on nothing.
package pbs_pkg;

	localparam int ADDR_W     = 17;
	localparam int CHAN_W     = 8;
	localparam int WORD_W     = 3 * CHAN_W;
	localparam int SUM_W      = 10;
	localparam int THR_W      = 10;
	localparam int ALPHA_W    = 9;
	localparam int LIMIT_W    = 8;
	localparam int CNT_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int BLEND_W    = 17;
	localparam int ROUND_HALF = 128;

	localparam int NUM_PIXELS_DEF = 131072;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

	localparam logic [THR_W-1:0]   THR_RESET       = 10'd30;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 9'd13;
	localparam logic               SELECTIVE_RESET = 1'b0;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 8'd50;
	localparam logic               COLOUR_RESET    = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIFF_THRESHOLD   = 3'd0,
		CFG_BLEND_ALPHA      = 3'd1,
		CFG_SELECTIVE_UPDATE = 3'd2,
		CFG_GHOST_LIMIT      = 3'd3,
		CFG_COLOUR_MODE      = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] pixel_addr;
		logic [CHAN_W-1:0] chan_zero;
		logic [CHAN_W-1:0] chan_one;
		logic [CHAN_W-1:0] chan_two;
		logic              load_bkg;
	} pix_item_t;

	typedef struct packed {
		logic              fg_flag;
		logic [ADDR_W-1:0] addr_out;
		logic [SUM_W-1:0]  diff_sum;
		logic              ghost_fired;
	} res_item_t;

	typedef struct packed {
		logic [THR_W-1:0]   diff_threshold;
		logic [ALPHA_W-1:0] blend_alpha;
		logic               selective_update;
		logic [LIMIT_W-1:0] ghost_limit;
		logic               colour_mode;
	} cfg_t;

	typedef struct packed {
		logic              load;
		logic              fg;
		logic              ghost;
		logic              blend_en;
		logic              colour;
		logic [SUM_W-1:0]  sum;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] pix;
		logic [WORD_W-1:0] bkg;
		logic [CNT_W-1:0]  cnt;
	} dec_t;

	function automatic int idx_width(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	function automatic logic [CHAN_W-1:0] absdiff8(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [CHAN_W-1:0] blend8(input logic [CHAN_W-1:0] pix,
			input logic [CHAN_W-1:0] bkg, input logic [ALPHA_W-1:0] alpha);
		logic [ALPHA_W-1:0] beta;
		logic [BLEND_W-1:0] prod_p;
		logic [BLEND_W-1:0] prod_b;
		logic [BLEND_W-1:0] acc;
		beta   = ALPHA_ONE - alpha;
		prod_p = BLEND_W'(alpha) * BLEND_W'(pix);
		prod_b = BLEND_W'(beta) * BLEND_W'(bkg);
		acc    = prod_p + prod_b + BLEND_W'(ROUND_HALF);
		return acc[2*CHAN_W-1:CHAN_W];
	endfunction

endpackage

>>> design/pbs_index_map.sv
`timescale 1ns / 1ps
// First two pipeline stages: wraps the pixel address into the store depth by
// multiplication with a reciprocal. Depends on pbs_pkg.
module pbs_index_map #(
	parameter int NUM_PIXELS = pbs_pkg::NUM_PIXELS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      adv,
	input  logic                                      take,
	input  pbs_pkg::pix_item_t                        pix,
	output logic                                      v_s2,
	output pbs_pkg::pix_item_t                        item_s2,
	output logic [pbs_pkg::idx_width(NUM_PIXELS)-1:0] idx_s2
);

	localparam int IDX_W   = pbs_pkg::idx_width(NUM_PIXELS);
	localparam int SHIFT   = pbs_pkg::ADDR_W + $clog2(NUM_PIXELS);
	localparam int RECIP_W = pbs_pkg::ADDR_W + 2;
	localparam int PROD_W  = SHIFT + pbs_pkg::ADDR_W;
	localparam int NP_W    = $clog2(NUM_PIXELS + 1);
	localparam int MUL_W   = pbs_pkg::ADDR_W + NP_W;
	localparam longint unsigned RECIP =
		((64'd1 << SHIFT) + longint'(NUM_PIXELS) - 64'd1) / longint'(NUM_PIXELS);
	localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);
	localparam logic [NP_W-1:0]    NP_K    = NP_W'(NUM_PIXELS);

	logic                       v_s1;
	pbs_pkg::pix_item_t         item_s1;
	logic [PROD_W-1:0]          prod_s1;
	logic [PROD_W-1:0]          prod;
	logic [pbs_pkg::ADDR_W-1:0] quot;
	logic [MUL_W-1:0]           rem;

	assign prod = PROD_W'(pix.pixel_addr) * PROD_W'(RECIP_K);
	assign quot = prod_s1[SHIFT +: pbs_pkg::ADDR_W];
	assign rem  = MUL_W'(item_s1.pixel_addr) - MUL_W'(quot) * MUL_W'(NP_K);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= pix;
			prod_s1 <= prod;
			item_s2 <= item_s1;
			idx_s2  <= rem[IDX_W-1:0];
		end
	end

endmodule

>>> design/pbs_store.sv
`timescale 1ns / 1ps
// Per-pixel background and foreground run count memories with registered read
// and the sweep that zeroes the run counts after reset. Depends on pbs_pkg.
module pbs_store #(
	parameter int NUM_PIXELS = pbs_pkg::NUM_PIXELS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      rd_en,
	input  logic [pbs_pkg::idx_width(NUM_PIXELS)-1:0] rd_idx,
	output logic [pbs_pkg::WORD_W-1:0]                bkg_s3,
	output logic [pbs_pkg::CNT_W-1:0]                 cnt_s3,
	input  logic                                      wr_en,
	input  logic [pbs_pkg::idx_width(NUM_PIXELS)-1:0] wr_idx,
	input  logic [pbs_pkg::WORD_W-1:0]                wr_bkg,
	input  logic [pbs_pkg::CNT_W-1:0]                 wr_cnt,
	output logic                                      clr_busy
);

	localparam int IDX_W = pbs_pkg::idx_width(NUM_PIXELS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PIXELS - 1);

	logic [pbs_pkg::WORD_W-1:0] bkg_mem [NUM_PIXELS];
	logic [pbs_pkg::CNT_W-1:0]  cnt_mem [NUM_PIXELS];
	logic                       clr_busy_q;
	logic [IDX_W-1:0]           clr_idx_q;

	assign clr_busy = clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + IDX_W'(1);
			if (clr_idx_q == LAST_IDX) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bkg_mem[wr_idx] <= wr_bkg;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			cnt_mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			cnt_mem[wr_idx] <= wr_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			bkg_s3 <= bkg_mem[rd_idx];
			cnt_s3 <= cnt_mem[rd_idx];
		end
	end

endmodule

>>> design/pbs_classify.sv
`timescale 1ns / 1ps
// Stages three to five: channel differences, threshold test, run count and
// ghost removal decision. Depends on pbs_pkg.
module pbs_classify #(
	parameter int NUM_PIXELS = pbs_pkg::NUM_PIXELS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      en,
	input  logic                                      en_up,
	input  pbs_pkg::cfg_t                             cfg,
	input  logic                                      v_s2,
	input  pbs_pkg::pix_item_t                        item_s2,
	input  logic [pbs_pkg::idx_width(NUM_PIXELS)-1:0] idx_s2,
	input  logic [pbs_pkg::WORD_W-1:0]                bkg_s3,
	input  logic [pbs_pkg::CNT_W-1:0]                 cnt_s3,
	output logic                                      v_s3,
	output logic [pbs_pkg::idx_width(NUM_PIXELS)-1:0] idx_s3,
	output logic                                      v_s4,
	output logic [pbs_pkg::idx_width(NUM_PIXELS)-1:0] idx_s4,
	output logic                                      v_s5,
	output logic [pbs_pkg::idx_width(NUM_PIXELS)-1:0] idx_s5,
	output pbs_pkg::dec_t                             dec_s5
);

	localparam int CW = pbs_pkg::CHAN_W;

	pbs_pkg::pix_item_t         item_s3;
	pbs_pkg::pix_item_t         item_s4;
	logic [pbs_pkg::WORD_W-1:0] pix_s3;
	logic [pbs_pkg::WORD_W-1:0] pix_s4;
	logic [pbs_pkg::WORD_W-1:0] bkg_s4;
	logic [pbs_pkg::CNT_W-1:0]  cnt_s4;
	logic [2:0][CW-1:0]         diff;
	logic [2:0][CW-1:0]         diff_s4;
	logic [pbs_pkg::SUM_W-1:0]  sum;
	logic                       fg_raw;
	logic [pbs_pkg::CNT_W-1:0]  cnt_inc;
	logic                       ghost;
	logic                       fg;
	logic [pbs_pkg::WORD_W-1:0] bkg_eff;
	pbs_pkg::dec_t              dec;

	assign pix_s3 = {item_s3.chan_two, item_s3.chan_one, item_s3.chan_zero};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = pbs_pkg::absdiff8(pix_s3[i*CW +: CW], bkg_s3[i*CW +: CW]);
		end
	end

	always_comb begin
		sum = pbs_pkg::SUM_W'(diff_s4[0]);
		if (cfg.colour_mode) begin
			sum = sum + pbs_pkg::SUM_W'(diff_s4[1]) + pbs_pkg::SUM_W'(diff_s4[2]);
		end
		fg_raw  = sum > cfg.diff_threshold;
		cnt_inc = fg_raw ? (cnt_s4 + pbs_pkg::CNT_W'(1)) : '0;
		ghost   = cnt_inc >= cfg.ghost_limit;
		fg      = fg_raw & ~ghost;
		bkg_eff = bkg_s4;
		if (ghost) begin
			bkg_eff[CW-1:0] = pix_s4[CW-1:0];
			if (cfg.colour_mode) begin
				bkg_eff[pbs_pkg::WORD_W-1:CW] = pix_s4[pbs_pkg::WORD_W-1:CW];
			end
		end
		dec.load     = item_s4.load_bkg;
		dec.fg       = ~item_s4.load_bkg & fg;
		dec.ghost    = ~item_s4.load_bkg & ghost;
		dec.blend_en = ~cfg.selective_update | ~fg;
		dec.colour   = cfg.colour_mode;
		dec.sum      = item_s4.load_bkg ? '0 : sum;
		dec.addr     = item_s4.pixel_addr;
		dec.pix      = pix_s4;
		dec.bkg      = bkg_eff;
		dec.cnt      = (ghost || item_s4.load_bkg) ? '0 : cnt_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2 & en_up;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_up) begin
			item_s3 <= item_s2;
			idx_s3  <= idx_s2;
		end
		if (en) begin
			item_s4 <= item_s3;
			idx_s4  <= idx_s3;
			pix_s4  <= pix_s3;
			bkg_s4  <= bkg_s3;
			cnt_s4  <= cnt_s3;
			diff_s4 <= diff;
			idx_s5  <= idx_s4;
			dec_s5  <= dec;
		end
	end

endmodule

>>> design/pbs_blend.sv
`timescale 1ns / 1ps
// Write-back logic of the last stage: blends the background toward the pixel
// and forms the result item. Depends on pbs_pkg.
module pbs_blend (
	input  pbs_pkg::dec_t                dec,
	input  logic [pbs_pkg::ALPHA_W-1:0]  blend_alpha,
	output logic [pbs_pkg::WORD_W-1:0]   new_bkg,
	output logic [pbs_pkg::CNT_W-1:0]    new_cnt,
	output pbs_pkg::res_item_t           res
);

	localparam int CW = pbs_pkg::CHAN_W;

	logic [pbs_pkg::ALPHA_W-1:0] alpha;
	logic [2:0][CW-1:0]          mix;
	logic [pbs_pkg::WORD_W-1:0]  blended;

	assign alpha = (blend_alpha > pbs_pkg::ALPHA_ONE) ? pbs_pkg::ALPHA_ONE : blend_alpha;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mix[i] = pbs_pkg::blend8(dec.pix[i*CW +: CW], dec.bkg[i*CW +: CW], alpha);
		end
		blended = dec.bkg;
		if (dec.blend_en) begin
			blended[CW-1:0] = mix[0];
			if (dec.colour) begin
				blended[pbs_pkg::WORD_W-1:CW] = {mix[2], mix[1]};
			end
		end
		new_bkg = dec.load ? dec.pix : blended;
	end

	assign new_cnt         = dec.cnt;
	assign res.fg_flag     = dec.fg;
	assign res.addr_out    = dec.addr;
	assign res.diff_sum    = dec.sum;
	assign res.ghost_fired = dec.ghost;

endmodule

>>> design/pixel_background_subtractor.sv
`timescale 1ns / 1ps
// Top level of the pixel background subtractor: configuration registers,
// stall control and result register. Depends on pbs_pkg and all pbs_ modules.
//
// Usage: pixel items enter on pix_valid/pix_ready/pix, results leave on
// res_valid/res_ready/res, one result per item and in order. Configuration is
// written through cfg_we/cfg_index/cfg_data while no item is in flight.
// Throughput: one item per cycle unless a hazard, the reset sweep or a result
// stall holds the pipeline. The background store is read two stages after
// acceptance and written back in stage five, so an item whose wrapped address
// matches one of the three items ahead of it waits at the read stage until
// that item has been written back; a raster stream never waits.
// Reset: the run count memory is zeroed by a sweep over all NUM_PIXELS entries
// (131072 by default), during which pix_ready is low. The background memory
// is not cleared and must be loaded before it is compared against.
// Stall: when a result waits with res_ready low, the whole pipeline holds and
// pix_ready falls; nothing is lost or repeated.
module pixel_background_subtractor #(
	parameter int NUM_PIXELS = pbs_pkg::NUM_PIXELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pix_valid,
	output logic                              pix_ready,
	input  pbs_pkg::pix_item_t                pix,
	output logic                              res_valid,
	input  logic                              res_ready,
	output pbs_pkg::res_item_t                res,
	input  logic                              cfg_we,
	input  logic [pbs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pbs_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IDX_W = pbs_pkg::idx_width(NUM_PIXELS);

	pbs_pkg::cfg_t              cfg_q;
	logic                       en;
	logic                       en_up;
	logic                       hazard;
	logic                       take;
	logic                       clr_busy;
	logic                       v_s2;
	logic                       v_s3;
	logic                       v_s4;
	logic                       v_s5;
	pbs_pkg::pix_item_t         item_s2;
	logic [IDX_W-1:0]           idx_s2;
	logic [IDX_W-1:0]           idx_s3;
	logic [IDX_W-1:0]           idx_s4;
	logic [IDX_W-1:0]           idx_s5;
	logic [pbs_pkg::WORD_W-1:0] bkg_s3;
	logic [pbs_pkg::CNT_W-1:0]  cnt_s3;
	pbs_pkg::dec_t              dec_s5;
	logic [pbs_pkg::WORD_W-1:0] new_bkg;
	logic [pbs_pkg::CNT_W-1:0]  new_cnt;
	pbs_pkg::res_item_t         res_d;
	logic                       res_valid_q;
	pbs_pkg::res_item_t         res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.diff_threshold   <= pbs_pkg::THR_RESET;
			cfg_q.blend_alpha      <= pbs_pkg::ALPHA_RESET;
			cfg_q.selective_update <= pbs_pkg::SELECTIVE_RESET;
			cfg_q.ghost_limit      <= pbs_pkg::LIMIT_RESET;
			cfg_q.colour_mode      <= pbs_pkg::COLOUR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pbs_pkg::CFG_DIFF_THRESHOLD: begin
					cfg_q.diff_threshold <= cfg_data[pbs_pkg::THR_W-1:0];
				end
				pbs_pkg::CFG_BLEND_ALPHA: begin
					cfg_q.blend_alpha <= cfg_data[pbs_pkg::ALPHA_W-1:0];
				end
				pbs_pkg::CFG_SELECTIVE_UPDATE: begin
					cfg_q.selective_update <= cfg_data[0];
				end
				pbs_pkg::CFG_GHOST_LIMIT: begin
					cfg_q.ghost_limit <= cfg_data[pbs_pkg::LIMIT_W-1:0];
				end
				pbs_pkg::CFG_COLOUR_MODE: begin
					cfg_q.colour_mode <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign en        = ~res_valid_q | res_ready;
	assign hazard    = v_s2 & ((v_s3 && (idx_s3 == idx_s2)) ||
	                           (v_s4 && (idx_s4 == idx_s2)) ||
	                           (v_s5 && (idx_s5 == idx_s2)));
	assign en_up     = en & ~hazard;
	assign pix_ready = en_up & ~clr_busy;
	assign take      = pix_valid & pix_ready;

	pbs_index_map #(
		.NUM_PIXELS(NUM_PIXELS)
	) u_index_map (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (en_up),
		.take   (take),
		.pix    (pix),
		.v_s2   (v_s2),
		.item_s2(item_s2),
		.idx_s2 (idx_s2)
	);

	pbs_store #(
		.NUM_PIXELS(NUM_PIXELS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (en_up),
		.rd_idx  (idx_s2),
		.bkg_s3  (bkg_s3),
		.cnt_s3  (cnt_s3),
		.wr_en   (en & v_s5),
		.wr_idx  (idx_s5),
		.wr_bkg  (new_bkg),
		.wr_cnt  (new_cnt),
		.clr_busy(clr_busy)
	);

	pbs_classify #(
		.NUM_PIXELS(NUM_PIXELS)
	) u_classify (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.en_up  (en_up),
		.cfg    (cfg_q),
		.v_s2   (v_s2),
		.item_s2(item_s2),
		.idx_s2 (idx_s2),
		.bkg_s3 (bkg_s3),
		.cnt_s3 (cnt_s3),
		.v_s3   (v_s3),
		.idx_s3 (idx_s3),
		.v_s4   (v_s4),
		.idx_s4 (idx_s4),
		.v_s5   (v_s5),
		.idx_s5 (idx_s5),
		.dec_s5 (dec_s5)
	);

	pbs_blend u_blend (
		.dec        (dec_s5),
		.blend_alpha(cfg_q.blend_alpha),
		.new_bkg    (new_bkg),
		.new_cnt    (new_cnt),
		.res        (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Items between the read and the write-back of the store never share an entry.
	a_no_alias_34: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && v_s4) |-> (idx_s3 != idx_s4))
		else $error("two items in flight on one store entry (stages 3 and 4)");

	a_no_alias_35: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && v_s5) |-> (idx_s3 != idx_s5))
		else $error("two items in flight on one store entry (stages 3 and 5)");

	a_no_alias_45: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && v_s5) |-> (idx_s4 != idx_s5))
		else $error("two items in flight on one store entry (stages 4 and 5)");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> (!pix_ready && !v_s5 && !res_valid))
		else $error("item in flight during the run count sweep");

	a_ghost_clears_fg: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.fg_flag && res.ghost_fired))
		else $error("ghost removal left the foreground mark set");

endmodule

>>> dv/tb_pixel_background_subtractor.sv
`timescale 1ns / 1ps
// Testbench of pixel_background_subtractor: a directed table of pixel items and
// register writes, then random phases under several register settings, with every
// result checked by its table row or predictor. Depends on pbs_pkg and the design.
module tb_pixel_background_subtractor;
	import pbs_pkg::*;

	localparam int unsigned NUM_PIX = NUM_PIXELS_DEF;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 12;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 66;
	localparam int POOL_DEPTH   = 24;
	localparam int LONG_HOLD    = 300;

	typedef enum logic [1:0] {
		BURST_NEAR,
		BURST_FAR,
		BURST_RANDOM
	} burst_t;

	typedef struct packed {
		logic                  is_cfg;
		cfg_reg_t              reg_idx;
		logic [CFG_DATA_W-1:0] value;
		pix_item_t             item;
		logic                  typed;
		res_item_t             want;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_ready;
	pix_item_t             pix = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	res_item_t             res;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	cfg_t                  regs_now;
	logic [WORD_W-1:0]     bkg_copy [int unsigned];
	logic [CNT_W-1:0]      fg_runs [int unsigned];
	res_item_t             pending_masks [$];
	logic [ADDR_W-1:0]     addr_pool [$];
	stim_row_t             directed_rows [$];
	res_item_t             want_r;

	bit long_hold_req = 1'b0;
	int cycle_count = 0;
	int mismatches = 0;
	int items_sent = 0;
	int results_checked = 0;
	int fg_count = 0;
	int ghost_count = 0;

	pixel_background_subtractor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic res_item_t classify_pixel(input pix_item_t it);
		int unsigned key;
		int unsigned nch;
		int unsigned sum;
		int unsigned cnt;
		int unsigned alpha;
		int unsigned i;
		logic [CHAN_W-1:0] pb [3];
		logic [CHAN_W-1:0] bb [3];
		logic [WORD_W-1:0] word;
		logic fg;
		logic ghost;
		res_item_t r;
		key = it.pixel_addr % NUM_PIX;
		pb[0] = it.chan_zero;
		pb[1] = it.chan_one;
		pb[2] = it.chan_two;
		r = '0;
		r.addr_out = it.pixel_addr;
		if (it.load_bkg) begin
			bkg_copy[key] = {pb[2], pb[1], pb[0]};
			fg_runs[key] = '0;
			return r;
		end
		word = bkg_copy.exists(key) ? bkg_copy[key] : '0;
		bb[0] = word[7:0];
		bb[1] = word[15:8];
		bb[2] = word[23:16];
		nch = regs_now.colour_mode ? 3 : 1;
		sum = 0;
		for (i = 0; i < nch; i++)
			sum += (pb[i] >= bb[i]) ? pb[i] - bb[i] : bb[i] - pb[i];
		fg = (sum > regs_now.diff_threshold);
		cnt = 0;
		if (fg)
			cnt = ((fg_runs.exists(key) ? fg_runs[key] : 0) + 1) & 8'hFF;
		ghost = 1'b0;
		if (cnt >= regs_now.ghost_limit) begin
			ghost = 1'b1;
			fg = 1'b0;
			cnt = 0;
			for (i = 0; i < nch; i++)
				bb[i] = pb[i];
		end
		fg_runs[key] = CNT_W'(cnt);
		alpha = (regs_now.blend_alpha > ALPHA_ONE) ? ALPHA_ONE : regs_now.blend_alpha;
		if (!regs_now.selective_update || !fg) begin
			for (i = 0; i < nch; i++)
				bb[i] = CHAN_W'((alpha * pb[i] + (256 - alpha) * bb[i] + 128) >> 8);
		end
		bkg_copy[key] = {bb[2], bb[1], bb[0]};
		r.fg_flag = fg;
		r.diff_sum = SUM_W'(sum);
		r.ghost_fired = ghost;
		return r;
	endfunction

	function automatic int pick_gap(input bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic void add_cfg(input cfg_reg_t idx, input int val);
		stim_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.reg_idx = idx;
		row.value = CFG_DATA_W'(val);
		directed_rows.push_back(row);
	endfunction

	function automatic void add_pix(input int addr, input int c0, input int c1, input int c2,
			input int ld, input int typed, input int fg, input int sum, input int gh);
		stim_row_t row;
		row = '0;
		row.item.pixel_addr = ADDR_W'(addr);
		row.item.chan_zero = CHAN_W'(c0);
		row.item.chan_one = CHAN_W'(c1);
		row.item.chan_two = CHAN_W'(c2);
		row.item.load_bkg = ld[0];
		row.typed = typed[0];
		row.want.fg_flag = fg[0];
		row.want.addr_out = ADDR_W'(addr);
		row.want.diff_sum = SUM_W'(sum);
		row.want.ghost_fired = gh[0];
		directed_rows.push_back(row);
	endfunction

	task automatic send_pixel(input pix_item_t it, input int gap, input logic typed,
			input res_item_t want);
		res_item_t predicted;
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix <= it;
		do @(posedge clk); while (!pix_ready);
		predicted = classify_pixel(it);
		pending_masks.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	task automatic wait_idle();
		pix_valid <= 1'b0;
		while (pending_masks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_DIFF_THRESHOLD:   regs_now.diff_threshold = val[THR_W-1:0];
			CFG_BLEND_ALPHA:      regs_now.blend_alpha = val[ALPHA_W-1:0];
			CFG_SELECTIVE_UPDATE: regs_now.selective_update = val[0];
			CFG_GHOST_LIMIT:      regs_now.ghost_limit = val[LIMIT_W-1:0];
			CFG_COLOUR_MODE:      regs_now.colour_mode = val[0];
			default: ;
		endcase
	endtask

	task automatic run_phase(input int n_items, input bit quiet);
		int sent;
		int r;
		int len;
		int k;
		int ci;
		int v;
		int unsigned key;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] bw;
		logic [CHAN_W-1:0] ch [3];
		burst_t mode;
		pix_item_t it;
		res_item_t none;
		none = '0;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			it = '0;
			if (r < 14 || addr_pool.size() == 0) begin
				it.pixel_addr = ADDR_W'($urandom_range(0, NUM_PIX - 1));
				it.chan_zero = CHAN_W'($urandom);
				it.chan_one = CHAN_W'($urandom);
				it.chan_two = CHAN_W'($urandom);
				it.load_bkg = 1'b1;
				send_pixel(it, pick_gap(quiet), 1'b0, none);
				if (addr_pool.size() >= POOL_DEPTH)
					void'(addr_pool.pop_front());
				addr_pool.push_back(it.pixel_addr);
				sent++;
			end else if (r < 22) begin
				// Noise: fully random pixels, and reloads, on known addresses.
				it.pixel_addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
				it.chan_zero = CHAN_W'($urandom);
				it.chan_one = CHAN_W'($urandom);
				it.chan_two = CHAN_W'($urandom);
				it.load_bkg = 1'($urandom_range(0, 1));
				send_pixel(it, pick_gap(quiet), 1'b0, none);
				sent++;
			end else begin
				addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
				len = $urandom_range(1, 8);
				case ($urandom_range(0, 9))
					0, 1: mode = BURST_RANDOM;
					2, 3, 4, 5: mode = BURST_FAR;
					default: mode = BURST_NEAR;
				endcase
				for (k = 0; k < len && sent < n_items; k++) begin
					if ($urandom_range(0, 4) == 0)
						addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
					key = addr % NUM_PIX;
					bw = bkg_copy[key];
					for (ci = 0; ci < 3; ci++) begin
						case (mode)
							BURST_NEAR: begin
								v = int'($urandom_range(0, 24)) - 12 + int'(bw[8*ci +: 8]);
								if (v < 0)
									v = 0;
								if (v > 255)
									v = 255;
								ch[ci] = CHAN_W'(v);
							end
							BURST_FAR: ch[ci] = bw[8*ci +: 8] ^ 8'h80 ^ CHAN_W'($urandom_range(0, 31));
							default: ch[ci] = CHAN_W'($urandom_range(0, 255));
						endcase
					end
					it = '0;
					it.pixel_addr = addr;
					it.chan_zero = ch[0];
					it.chan_one = ch[1];
					it.chan_two = ch[2];
					send_pixel(it, pick_gap(quiet), 1'b0, none);
					sent++;
				end
			end
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_pixel_background_subtractor NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (pending_masks.size() == 0) begin
				$error("result for address %0d arrived with no item outstanding", res.addr_out);
				mismatches++;
			end else begin
				want_r = pending_masks.pop_front();
				results_checked++;
				if (res.fg_flag !== want_r.fg_flag) begin
					$error("fg_flag: expected %0d, got %0d", want_r.fg_flag, res.fg_flag);
					mismatches++;
				end
				if (res.addr_out !== want_r.addr_out) begin
					$error("addr_out: expected %0d, got %0d", want_r.addr_out, res.addr_out);
					mismatches++;
				end
				if (res.diff_sum !== want_r.diff_sum) begin
					$error("diff_sum: expected %0d, got %0d", want_r.diff_sum, res.diff_sum);
					mismatches++;
				end
				if (res.ghost_fired !== want_r.ghost_fired) begin
					$error("ghost_fired: expected %0d, got %0d", want_r.ghost_fired,
						res.ghost_fired);
					mismatches++;
				end
				if (res.fg_flag === 1'b1)
					fg_count++;
				if (res.ghost_fired === 1'b1)
					ghost_count++;
			end
		end
	end

	initial begin
		int run_len;
		int hold;
		int k;
		int r;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			res_ready <= 1'b1;
			run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20);
			k = 0;
			do begin
				@(posedge clk);
				k++;
			end while (k < run_len && !long_hold_req);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55)
					hold = 0;
				else if (r < 85)
					hold = $urandom_range(1, 3);
				else if (r < 96)
					hold = $urandom_range(4, 12);
				else
					hold = $urandom_range(20, 60);
			end
			if (hold > 0) begin
				res_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
		end
	end

	initial begin
		int i;
		int ph;
		stim_row_t row;
		cfg_t c;
		regs_now.diff_threshold = THR_RESET;
		regs_now.blend_alpha = ALPHA_RESET;
		regs_now.selective_update = SELECTIVE_RESET;
		regs_now.ghost_limit = LIMIT_RESET;
		regs_now.colour_mode = COLOUR_RESET;

		add_pix(0, 0, 0, 0, 1, 1, 0, 0, 0);
		add_pix(131071, 255, 255, 255, 1, 1, 0, 0, 0);
		add_pix(77, 'h80, 'h40, 'h20, 1, 1, 0, 0, 0);
		add_pix(0, 255, 'h5a, 'ha5, 0, 1, 1, 255, 0);
		add_pix(131071, 0, 0, 0, 0, 1, 1, 255, 0);
		add_pix(77, 'h9e, 0, 0, 0, 1, 0, 30, 0);
		add_pix(77, 'ha1, 'h40, 'h20, 0, 0, 0, 0, 0);
		add_cfg(CFG_COLOUR_MODE, 1);
		add_pix(131071, 0, 0, 0, 0, 0, 0, 0, 0);
		add_pix(77, 'h80, 'h40, 'h20, 0, 0, 0, 0, 0);
		add_cfg(CFG_DIFF_THRESHOLD, 1023);
		add_pix(5, 0, 0, 0, 1, 1, 0, 0, 0);
		add_pix(5, 255, 255, 255, 0, 1, 0, 765, 0);
		add_cfg(CFG_BLEND_ALPHA, 511);
		add_cfg(CFG_DIFF_THRESHOLD, 0);
		add_pix(5, 1, 2, 3, 0, 0, 0, 0, 0);
		add_pix(5, 1, 2, 3, 0, 0, 0, 0, 0);
		add_cfg(CFG_GHOST_LIMIT, 0);
		add_pix(5, 9, 9, 9, 0, 0, 0, 0, 0);
		add_cfg(CFG_SELECTIVE_UPDATE, 1);
		add_cfg(CFG_GHOST_LIMIT, 2);
		add_cfg(CFG_BLEND_ALPHA, 0);
		add_cfg(CFG_DIFF_THRESHOLD, 10);
		add_pix(0, 200, 200, 200, 0, 0, 0, 0, 0);
		add_pix(0, 200, 200, 200, 0, 0, 0, 0, 0);
		add_pix(0, 200, 200, 200, 0, 0, 0, 0, 0);
		add_pix(131071, 'h55, 'haa, 'h55, 1, 1, 0, 0, 0);
		add_cfg(CFG_COLOUR_MODE, 0);
		add_cfg(CFG_SELECTIVE_UPDATE, 0);
		add_pix(131071, 'haa, 0, 'hff, 0, 0, 0, 0, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < directed_rows.size(); i++) begin
			row = directed_rows[i];
			if (row.is_cfg) begin
				wait_idle();
				write_reg(row.reg_idx, row.value);
			end else begin
				send_pixel(row.item, pick_gap(1'b0), row.typed, row.want);
			end
		end

		for (ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			case (ph)
				0: c = '{diff_threshold: 0, blend_alpha: 0, selective_update: 0,
					ghost_limit: 1, colour_mode: 1};
				1: c = '{diff_threshold: 1023, blend_alpha: 511, selective_update: 1,
					ghost_limit: 255, colour_mode: 0};
				2: c = '{diff_threshold: 765, blend_alpha: 256, selective_update: 1,
					ghost_limit: 0, colour_mode: 1};
				default: begin
					c.diff_threshold = ($urandom_range(0, 4) == 0) ?
						THR_W'($urandom_range(0, 1023)) : THR_W'($urandom_range(0, 120));
					c.blend_alpha = ($urandom_range(0, 1) == 0) ?
						ALPHA_W'($urandom_range(0, 256)) : ALPHA_W'($urandom_range(0, 511));
					c.selective_update = 1'($urandom_range(0, 1));
					c.ghost_limit = ($urandom_range(0, 5) == 0) ?
						LIMIT_W'($urandom_range(0, 255)) : LIMIT_W'($urandom_range(1, 6));
					c.colour_mode = 1'($urandom_range(0, 1));
				end
			endcase
			write_reg(CFG_DIFF_THRESHOLD, CFG_DATA_W'(c.diff_threshold));
			write_reg(CFG_BLEND_ALPHA, CFG_DATA_W'(c.blend_alpha));
			write_reg(CFG_SELECTIVE_UPDATE, CFG_DATA_W'(c.selective_update));
			write_reg(CFG_GHOST_LIMIT, CFG_DATA_W'(c.ghost_limit));
			write_reg(CFG_COLOUR_MODE, CFG_DATA_W'(c.colour_mode));
			// The result side holds off for a long stretch while items keep coming.
			if (ph == 3)
				long_hold_req = 1'b1;
			run_phase(PHASE_ITEMS, ph == 3 || ph == 6);
		end

		wait_idle();
		$display("Covered %0d pixel items over the directed table and %0d register settings;",
			items_sent, PHASES);
		$display("%0d results compared, %0d foreground, %0d ghost removals, %0d mismatches.",
			results_checked, fg_count, ghost_count, mismatches);
		if (mismatches == 0 && pending_masks.size() == 0)
			$display("tb_pixel_background_subtractor OK");
		else
			$display("tb_pixel_background_subtractor NOT OK");
		$finish;
	end

endmodule

>>> files.f
design/pbs_pkg.sv
design/pbs_index_map.sv
design/pbs_store.sv
design/pbs_classify.sv
design/pbs_blend.sv
design/pixel_background_subtractor.sv
dv/tb_pixel_background_subtractor.sv
